// ===== hdl/fbsg_pkg.sv =====
// Shared types, constants and helpers for the FAT boot sector geometry pipeline.
// Used by every module under hdl/; depends on nothing.
`default_nettype none

package fbsg_pkg;

    localparam int DIVIDEND_W    = 21;
    localparam int DIVISOR_W     = 16;
    localparam int DIV_STEPS     = 3;
    localparam int DIV_STAGES    = DIVIDEND_W / DIV_STEPS;
    localparam int DIR_ENTRY_SHIFT = 5;
    localparam int FAT_AREA_W    = 17;
    localparam int OVH_A_W       = 18;
    localparam int OVH_W         = 22;
    localparam int SHIFT_W       = 3;
    localparam int POS_W         = 32;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_BAD_CLUSTER = 3'd1,
        ST_BAD_COUNTS  = 3'd2,
        ST_BAD_FATS    = 3'd3,
        ST_ZERO_BPS    = 3'd4
    } t_status;

    typedef struct packed {
        t_status                 status;
        logic [POS_W-1:0]        fat_start;
        logic [FAT_AREA_W-1:0]   fat_area;
        logic [15:0]             rsv;
        logic [POS_W-1:0]        vsec;
        logic [SHIFT_W-1:0]      shift;
    } t_side;

    // rem: partial remainder; work: dividend bits shifting out, quotient bits in
    typedef struct packed {
        logic [DIVISOR_W-1:0]    rem;
        logic [DIVIDEND_W-1:0]   work;
        logic [DIVISOR_W-1:0]    divisor;
        t_side                   side;
    } t_div_word;

    function automatic logic [SHIFT_W-1:0] f_log2_8(input logic [7:0] v);
        logic [SHIFT_W-1:0] res;
        res = '0;
        for (int i = 0; i < 8; i++) begin
            if (v[i]) begin
                res = SHIFT_W'(i);
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/fbsg_decode.sv =====
// Entry stage: boot sector checks, FAT start, FAT area, sector count select.
// Depends on fbsg_pkg.
`default_nettype none

module fbsg_decode (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [31:0]          i_volume_start,
    input  wire logic [15:0]          i_sector_size,
    input  wire logic [7:0]           i_cluster_sectors,
    input  wire logic [15:0]          i_reserved_count,
    input  wire logic [7:0]           i_fat_copies,
    input  wire logic [15:0]          i_root_entries,
    input  wire logic [15:0]          i_total_small,
    input  wire logic [31:0]          i_total_large,
    input  wire logic [15:0]          i_fat_length,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output fbsg_pkg::t_div_word       o_word
);

    logic                 r_valid;
    fbsg_pkg::t_div_word  r_word;
    fbsg_pkg::t_div_word  n_word;
    logic                 en;
    logic                 cluster_ok;

    assign en      = !r_valid || i_ready;
    assign o_ready = en;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    assign cluster_ok = (i_cluster_sectors != 8'd0) &&
                        ((i_cluster_sectors & (i_cluster_sectors - 8'd1)) == 8'd0);

    always_comb begin
        priority if (!cluster_ok) begin
            n_word.side.status = fbsg_pkg::ST_BAD_CLUSTER;
        end else if ((i_total_small == 16'd0) == (i_total_large == 32'd0)) begin
            n_word.side.status = fbsg_pkg::ST_BAD_COUNTS;
        end else if (i_fat_copies != 8'd1 && i_fat_copies != 8'd2) begin
            n_word.side.status = fbsg_pkg::ST_BAD_FATS;
        end else if (i_sector_size == 16'd0) begin
            n_word.side.status = fbsg_pkg::ST_ZERO_BPS;
        end else begin
            n_word.side.status = fbsg_pkg::ST_OK;
        end
        n_word.side.fat_start = i_volume_start + {16'd0, i_reserved_count};
        n_word.side.fat_area  = (i_fat_copies == 8'd2) ? {i_fat_length, 1'b0}
                                                       : {1'b0, i_fat_length};
        n_word.side.rsv       = i_reserved_count;
        n_word.side.vsec      = (i_total_small != 16'd0) ? {16'd0, i_total_small}
                                                         : i_total_large;
        n_word.side.shift     = fbsg_pkg::f_log2_8(i_cluster_sectors);
        n_word.rem            = '0;
        n_word.work           = {i_root_entries, {fbsg_pkg::DIR_ENTRY_SHIFT{1'b0}}};
        n_word.divisor        = i_sector_size;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && i_valid) begin
            r_word <= n_word;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/fbsg_div_stage.sv =====
// One stage of the root directory length divider: DIV_STEPS restoring steps.
// Depends on fbsg_pkg.
`default_nettype none

module fbsg_div_stage (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire fbsg_pkg::t_div_word  i_word,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output fbsg_pkg::t_div_word       o_word
);

    logic                 r_valid;
    fbsg_pkg::t_div_word  r_word;
    fbsg_pkg::t_div_word  n_word;
    logic                 en;

    assign en      = !r_valid || i_ready;
    assign o_ready = en;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_comb begin : p_step
        logic [fbsg_pkg::DIVISOR_W:0] partial;
        logic [fbsg_pkg::DIVISOR_W:0] diff;
        logic                         qbit;
        n_word = i_word;
        for (int k = 0; k < fbsg_pkg::DIV_STEPS; k++) begin
            partial = {n_word.rem, n_word.work[fbsg_pkg::DIVIDEND_W-1]};
            diff    = partial - {1'b0, n_word.divisor};
            qbit    = (partial >= {1'b0, n_word.divisor});
            n_word.rem  = qbit ? diff[fbsg_pkg::DIVISOR_W-1:0]
                               : partial[fbsg_pkg::DIVISOR_W-1:0];
            n_word.work = {n_word.work[fbsg_pkg::DIVIDEND_W-2:0], qbit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && i_valid) begin
            r_word <= n_word;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/fbsg_finish.sv =====
// Last three stages: round up the root length, place root and data area,
// count clusters and register the result word. Depends on fbsg_pkg.
`default_nettype none

module fbsg_finish (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire fbsg_pkg::t_div_word  i_word,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [2:0]                o_status,
    output logic [31:0]               o_fat_start,
    output logic [31:0]               o_root_start,
    output logic [20:0]               o_root_length,
    output logic [31:0]               o_data_start,
    output logic [31:0]               o_total_sectors,
    output logic [31:0]               o_cluster_total
);

    typedef struct packed {
        fbsg_pkg::t_status                  status;
        logic [fbsg_pkg::POS_W-1:0]         fat_start;
        logic [fbsg_pkg::POS_W-1:0]         root_start;
        logic [fbsg_pkg::DIVIDEND_W-1:0]    rlen;
        logic [fbsg_pkg::OVH_A_W-1:0]       ovh_a;
        logic [fbsg_pkg::POS_W-1:0]         vsec;
        logic [fbsg_pkg::SHIFT_W-1:0]       shift;
    } t_fin_a;

    typedef struct packed {
        fbsg_pkg::t_status                  status;
        logic [fbsg_pkg::POS_W-1:0]         fat_start;
        logic [fbsg_pkg::POS_W-1:0]         root_start;
        logic [fbsg_pkg::DIVIDEND_W-1:0]    rlen;
        logic [fbsg_pkg::POS_W-1:0]         data_start;
        logic [fbsg_pkg::POS_W-1:0]         vsec;
        logic [fbsg_pkg::POS_W:0]           diff;
        logic [fbsg_pkg::SHIFT_W-1:0]       shift;
    } t_fin_b;

    logic    r_valid_a, r_valid_b, r_valid_c;
    logic    en_a, en_b, en_c;
    t_fin_a  r_a, n_a;
    t_fin_b  r_b, n_b;
    logic [fbsg_pkg::OVH_W-1:0] ovh;
    logic    ok;

    fbsg_pkg::t_status              r_status;
    logic [fbsg_pkg::POS_W-1:0]     r_fat_start, r_root_start, r_data_start;
    logic [fbsg_pkg::POS_W-1:0]     r_total_sectors, r_cluster_total;
    logic [fbsg_pkg::DIVIDEND_W-1:0] r_root_length;

    assign en_c    = !r_valid_c || i_ready;
    assign en_b    = !r_valid_b || en_c;
    assign en_a    = !r_valid_a || en_b;
    assign o_ready = en_a;
    assign o_valid = r_valid_c;

    always_comb begin
        n_a.status     = i_word.side.status;
        n_a.fat_start  = i_word.side.fat_start;
        n_a.root_start = i_word.side.fat_start +
                         {{(fbsg_pkg::POS_W-fbsg_pkg::FAT_AREA_W){1'b0}}, i_word.side.fat_area};
        n_a.rlen       = i_word.work + {{(fbsg_pkg::DIVIDEND_W-1){1'b0}}, |i_word.rem};
        n_a.ovh_a      = {2'b00, i_word.side.rsv} + {1'b0, i_word.side.fat_area};
        n_a.vsec       = i_word.side.vsec;
        n_a.shift      = i_word.side.shift;
    end

    assign ovh = {{(fbsg_pkg::OVH_W-fbsg_pkg::OVH_A_W){1'b0}}, r_a.ovh_a} +
                 {{(fbsg_pkg::OVH_W-fbsg_pkg::DIVIDEND_W){1'b0}}, r_a.rlen};

    always_comb begin
        n_b.status     = r_a.status;
        n_b.fat_start  = r_a.fat_start;
        n_b.root_start = r_a.root_start;
        n_b.rlen       = r_a.rlen;
        n_b.data_start = r_a.root_start +
                         {{(fbsg_pkg::POS_W-fbsg_pkg::DIVIDEND_W){1'b0}}, r_a.rlen};
        n_b.vsec       = r_a.vsec;
        n_b.diff       = {1'b0, r_a.vsec} -
                         {{(fbsg_pkg::POS_W+1-fbsg_pkg::OVH_W){1'b0}}, ovh};
        n_b.shift      = r_a.shift;
    end

    assign ok = (r_b.status == fbsg_pkg::ST_OK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
            r_valid_c <= 1'b0;
        end else begin
            if (en_a) begin
                r_valid_a <= i_valid;
            end
            if (en_b) begin
                r_valid_b <= r_valid_a;
            end
            if (en_c) begin
                r_valid_c <= r_valid_b;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a && i_valid) begin
            r_a <= n_a;
        end
        if (en_b && r_valid_a) begin
            r_b <= n_b;
        end
        if (en_c && r_valid_b) begin
            r_status         <= r_b.status;
            r_fat_start      <= ok ? r_b.fat_start  : '0;
            r_root_start     <= ok ? r_b.root_start : '0;
            r_root_length    <= ok ? r_b.rlen       : '0;
            r_data_start     <= ok ? r_b.data_start : '0;
            r_total_sectors  <= ok ? r_b.vsec       : '0;
            // negative difference: overhead exceeds the volume
            r_cluster_total  <= (ok && !r_b.diff[fbsg_pkg::POS_W]) ?
                                (r_b.diff[fbsg_pkg::POS_W-1:0] >> r_b.shift) : '0;
        end
    end

    assign o_status         = r_status;
    assign o_fat_start      = r_fat_start;
    assign o_root_start     = r_root_start;
    assign o_root_length    = r_root_length;
    assign o_data_start     = r_data_start;
    assign o_total_sectors  = r_total_sectors;
    assign o_cluster_total  = r_cluster_total;

endmodule

`default_nettype wire

// ===== hdl/fat_boot_sector_geometry.sv =====
// Top level of the FAT boot sector geometry pipeline.
// Depends on fbsg_pkg, fbsg_decode, fbsg_div_stage and fbsg_finish.
//
//   channel  | handshake          | word
//   ---------+--------------------+---------------------------------------------
//   input    | i_valid / o_ready  | boot sector fields and volume start
//   output   | o_valid / i_ready  | status, region starts, lengths, cluster count
//
// One word enters per cycle unless stalled and passes one decode stage, seven
// divider stages of three restoring steps each for the root length and three
// finishing stages. Reset clears only the stage valid bits. A stalled output
// holds its word; upstream stages keep filling bubbles and stall only when full.
`default_nettype none

module fat_boot_sector_geometry (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire logic [31:0]  i_volume_start,
    input  wire logic [15:0]  i_sector_size,
    input  wire logic [7:0]   i_cluster_sectors,
    input  wire logic [15:0]  i_reserved_count,
    input  wire logic [7:0]   i_fat_copies,
    input  wire logic [15:0]  i_root_entries,
    input  wire logic [15:0]  i_total_small,
    input  wire logic [31:0]  i_total_large,
    input  wire logic [15:0]  i_fat_length,
    output logic              o_valid,
    input  wire logic         i_ready,
    output logic [2:0]        o_status,
    output logic [31:0]       o_fat_start,
    output logic [31:0]       o_root_start,
    output logic [20:0]       o_root_length,
    output logic [31:0]       o_data_start,
    output logic [31:0]       o_total_sectors,
    output logic [31:0]       o_cluster_total
);

    logic [fbsg_pkg::DIV_STAGES:0] div_valid;
    logic [fbsg_pkg::DIV_STAGES:0] div_ready;
    fbsg_pkg::t_div_word           div_word [fbsg_pkg::DIV_STAGES+1];

    fbsg_decode u_decode (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_volume_start     (i_volume_start),
        .i_sector_size      (i_sector_size),
        .i_cluster_sectors  (i_cluster_sectors),
        .i_reserved_count   (i_reserved_count),
        .i_fat_copies       (i_fat_copies),
        .i_root_entries     (i_root_entries),
        .i_total_small      (i_total_small),
        .i_total_large      (i_total_large),
        .i_fat_length       (i_fat_length),
        .o_valid            (div_valid[0]),
        .i_ready            (div_ready[0]),
        .o_word             (div_word[0])
    );

    for (genvar s = 0; s < fbsg_pkg::DIV_STAGES; s++) begin : g_div
        fbsg_div_stage u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (div_valid[s]),
            .o_ready (div_ready[s]),
            .i_word  (div_word[s]),
            .o_valid (div_valid[s+1]),
            .i_ready (div_ready[s+1]),
            .o_word  (div_word[s+1])
        );
    end

    fbsg_finish u_finish (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (div_valid[fbsg_pkg::DIV_STAGES]),
        .o_ready          (div_ready[fbsg_pkg::DIV_STAGES]),
        .i_word           (div_word[fbsg_pkg::DIV_STAGES]),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_status         (o_status),
        .o_fat_start      (o_fat_start),
        .o_root_start     (o_root_start),
        .o_root_length    (o_root_length),
        .o_data_start     (o_data_start),
        .o_total_sectors  (o_total_sectors),
        .o_cluster_total  (o_cluster_total)
    );

endmodule

`default_nettype wire

// ===== hdl/fbsg_checker.sv =====
// Port-level checks for fat_boot_sector_geometry, attached by bind.
// Depends on fbsg_pkg and the top level's port list.
`default_nettype none

module fbsg_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         o_valid,
    input wire logic         i_ready,
    input wire logic [2:0]   o_status,
    input wire logic [31:0]  o_fat_start,
    input wire logic [31:0]  o_root_start,
    input wire logic [20:0]  o_root_length,
    input wire logic [31:0]  o_data_start,
    input wire logic [31:0]  o_total_sectors,
    input wire logic [31:0]  o_cluster_total
);

    localparam logic [2:0] OK = fbsg_pkg::ST_OK;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data_start) && $stable(o_status))
        else $error("output word dropped or changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != OK |->
            o_fat_start == 32'd0 && o_root_start == 32'd0 && o_root_length == 21'd0 &&
            o_data_start == 32'd0 && o_total_sectors == 32'd0 && o_cluster_total == 32'd0)
        else $error("rejected boot sector with nonzero geometry");

    a_data_place: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == OK |->
            o_data_start == o_root_start + {11'd0, o_root_length})
        else $error("data area does not follow root directory");

    a_count_fit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == OK |->
            o_total_sectors != 32'd0 && o_cluster_total <= o_total_sectors)
        else $error("cluster count exceeds volume size");

endmodule

bind fat_boot_sector_geometry fbsg_checker u_fbsg_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_status         (o_status),
    .o_fat_start      (o_fat_start),
    .o_root_start     (o_root_start),
    .o_root_length    (o_root_length),
    .o_data_start     (o_data_start),
    .o_total_sectors  (o_total_sectors),
    .o_cluster_total  (o_cluster_total)
);

`default_nettype wire
